[rtl/core/cau_pkg.sv]
// Shared widths, codes, types and saturation helpers of the complex arithmetic unit.
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int SUM_W  = PROD_W + 1;
    localparam int ADD_W  = DATA_WIDTH + 1;
    localparam int NUM_W  = SUM_W + FRAC_BITS;
    localparam int QUO_W  = DATA_WIDTH + 1;
    localparam int HI_W   = NUM_W - QUO_W;
    localparam int DEN_W  = PROD_W;
    localparam int REM_W  = DEN_W + 1;

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;
    localparam logic [1:0] FUNC_MUL = 2'd2;
    localparam logic [1:0] FUNC_DIV = 2'd3;

    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_DZ  = 2'd1;
    localparam logic [1:0] STAT_SAT = 2'd2;

    localparam logic [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Per-item control and the finished add/sub/mul result
    typedef struct packed {
        logic                  is_div;
        logic                  dz;
        logic                  neg_re;
        logic                  neg_im;
        logic                  ovf_re;
        logic                  ovf_im;
        logic [DATA_WIDTH-1:0] alt_re;
        logic [DATA_WIDTH-1:0] alt_im;
        logic                  alt_sat;
    } side_t;

    typedef struct packed {
        logic                  sat;
        logic [DATA_WIDTH-1:0] val;
    } sat_t;

    // Clamp a wide signed value to the word range
    function automatic sat_t sat_word(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] smax;
        logic signed [SUM_W-1:0] smin;
        sat_t r;
        smax  = {{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
        smin  = ~smax;
        r.sat = 1'b0;
        r.val = x[DATA_WIDTH-1:0];
        if (x > smax)
        begin
            r.sat = 1'b1;
            r.val = WORD_MAX;
        end
        else if (x < smin)
        begin
            r.sat = 1'b1;
            r.val = WORD_MIN;
        end
        return r;
    endfunction

    // Apply sign to a quotient magnitude and clamp it
    function automatic sat_t sat_quot(input logic neg, input logic ovf,
                                      input logic [QUO_W-1:0] q);
        logic [QUO_W-1:0] lim;
        logic [QUO_W-1:0] nq;
        sat_t r;
        lim = {2'b00, {(DATA_WIDTH-1){1'b1}}} + {{(QUO_W-1){1'b0}}, neg};
        nq  = ~q + {{(QUO_W-1){1'b0}}, 1'b1};
        r.sat = 1'b0;
        r.val = neg ? nq[DATA_WIDTH-1:0] : q[DATA_WIDTH-1:0];
        if (ovf || (q > lim))
        begin
            r.sat = 1'b1;
            r.val = neg ? WORD_MIN : WORD_MAX;
        end
        return r;
    endfunction

endpackage

[rtl/core/cau_front.sv]
// Operand register, products, sums, magnitude and divider setup stages.
module cau_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [1:0]                        in_func,
    input  logic [4*cau_pkg::DATA_WIDTH-1:0]  in_data,
    output logic                              out_valid,
    output cau_pkg::side_t                    out_side,
    output logic [cau_pkg::DEN_W-1:0]         out_den,
    output logic [cau_pkg::DEN_W-1:0]         out_rem_re,
    output logic [cau_pkg::QUO_W-1:0]         out_nb_re,
    output logic [cau_pkg::DEN_W-1:0]         out_rem_im,
    output logic [cau_pkg::QUO_W-1:0]         out_nb_im
);

    localparam int W = cau_pkg::DATA_WIDTH;

    logic [4:0] valid_reg;

    // Stage A: operands
    logic [1:0]              func_a_reg;
    logic signed [W-1:0]     a_re_reg, a_im_reg, b_re_reg, b_im_reg;

    // Stage B: products and part sums
    logic [1:0]                          func_b_reg;
    logic signed [cau_pkg::PROD_W-1:0]   p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [cau_pkg::PROD_W-1:0]   p_bb_reg, p_qq_reg;
    logic signed [cau_pkg::ADD_W-1:0]    as_re_b_reg, as_im_b_reg;

    // Stage C: numerators and denominator
    logic [1:0]                          func_c_reg;
    logic signed [cau_pkg::SUM_W-1:0]    num_re_reg, num_im_reg;
    logic [cau_pkg::DEN_W-1:0]           den_c_reg;
    logic signed [cau_pkg::ADD_W-1:0]    as_re_c_reg, as_im_c_reg;

    // Stage D: magnitudes and pre-clamp values
    logic [1:0]                          func_d_reg;
    logic [cau_pkg::SUM_W-1:0]           mag_re_reg, mag_im_reg;
    logic                                neg_re_reg, neg_im_reg;
    logic signed [cau_pkg::SUM_W-1:0]    w_re_reg, w_im_reg;
    logic [cau_pkg::DEN_W-1:0]           den_d_reg;

    // Stage E: divider setup
    cau_pkg::side_t                      side_e_reg;
    logic [cau_pkg::DEN_W-1:0]           den_e_reg;
    logic [cau_pkg::DEN_W-1:0]           rem_re_reg, rem_im_reg;
    logic [cau_pkg::QUO_W-1:0]           nb_re_reg, nb_im_reg;

    logic [cau_pkg::NUM_W-1:0]           sh_re, sh_im;
    logic [cau_pkg::HI_W-1:0]            hi_re, hi_im;
    cau_pkg::sat_t                       sat_re, sat_im;

    function automatic logic signed [cau_pkg::ADD_W-1:0] ADD_EXT(input logic signed [W-1:0] x);
        return {x[W-1], x};
    endfunction

    function automatic logic signed [cau_pkg::SUM_W-1:0] SUM_EXT(
        input logic signed [cau_pkg::PROD_W-1:0] x);
        return {x[cau_pkg::PROD_W-1], x};
    endfunction

    function automatic logic signed [cau_pkg::SUM_W-1:0] SUM_EXT2(
        input logic signed [cau_pkg::ADD_W-1:0] x);
        return {{(cau_pkg::SUM_W-cau_pkg::ADD_W){x[cau_pkg::ADD_W-1]}}, x};
    endfunction

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_comb
    begin
        sh_re  = {mag_re_reg, {cau_pkg::FRAC_BITS{1'b0}}};
        sh_im  = {mag_im_reg, {cau_pkg::FRAC_BITS{1'b0}}};
        hi_re  = sh_re[cau_pkg::NUM_W-1:cau_pkg::QUO_W];
        hi_im  = sh_im[cau_pkg::NUM_W-1:cau_pkg::QUO_W];
        sat_re = cau_pkg::sat_word(w_re_reg);
        sat_im = cau_pkg::sat_word(w_im_reg);
    end

    // Payload stages, held while stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func_a_reg <= in_func;
            a_re_reg   <= in_data[W-1:0];
            a_im_reg   <= in_data[2*W-1:W];
            b_re_reg   <= in_data[3*W-1:2*W];
            b_im_reg   <= in_data[4*W-1:3*W];

            func_b_reg  <= func_a_reg;
            p_rr_reg    <= a_re_reg * b_re_reg;
            p_ii_reg    <= a_im_reg * b_im_reg;
            p_ri_reg    <= a_re_reg * b_im_reg;
            p_ir_reg    <= a_im_reg * b_re_reg;
            p_bb_reg    <= b_re_reg * b_re_reg;
            p_qq_reg    <= b_im_reg * b_im_reg;
            as_re_b_reg <= (func_a_reg == cau_pkg::FUNC_SUB)
                         ? ADD_EXT(a_re_reg) - ADD_EXT(b_re_reg)
                         : ADD_EXT(a_re_reg) + ADD_EXT(b_re_reg);
            as_im_b_reg <= (func_a_reg == cau_pkg::FUNC_SUB)
                         ? ADD_EXT(a_im_reg) - ADD_EXT(b_im_reg)
                         : ADD_EXT(a_im_reg) + ADD_EXT(b_im_reg);

            func_c_reg  <= func_b_reg;
            if (func_b_reg == cau_pkg::FUNC_DIV)
            begin
                num_re_reg <= SUM_EXT(p_rr_reg) + SUM_EXT(p_ii_reg);
                num_im_reg <= SUM_EXT(p_ir_reg) - SUM_EXT(p_ri_reg);
            end
            else
            begin
                num_re_reg <= SUM_EXT(p_rr_reg) - SUM_EXT(p_ii_reg);
                num_im_reg <= SUM_EXT(p_ri_reg) + SUM_EXT(p_ir_reg);
            end
            den_c_reg   <= $unsigned(p_bb_reg) + $unsigned(p_qq_reg);
            as_re_c_reg <= as_re_b_reg;
            as_im_c_reg <= as_im_b_reg;

            func_d_reg <= func_c_reg;
            neg_re_reg <= num_re_reg[cau_pkg::SUM_W-1];
            neg_im_reg <= num_im_reg[cau_pkg::SUM_W-1];
            mag_re_reg <= num_re_reg[cau_pkg::SUM_W-1] ? $unsigned(-num_re_reg)
                                                       : $unsigned(num_re_reg);
            mag_im_reg <= num_im_reg[cau_pkg::SUM_W-1] ? $unsigned(-num_im_reg)
                                                       : $unsigned(num_im_reg);
            if (func_c_reg == cau_pkg::FUNC_MUL)
            begin
                w_re_reg <= num_re_reg >>> cau_pkg::FRAC_BITS;
                w_im_reg <= num_im_reg >>> cau_pkg::FRAC_BITS;
            end
            else
            begin
                w_re_reg <= SUM_EXT2(as_re_c_reg);
                w_im_reg <= SUM_EXT2(as_im_c_reg);
            end
            den_d_reg <= den_c_reg;

            side_e_reg.is_div  <= (func_d_reg == cau_pkg::FUNC_DIV);
            side_e_reg.dz      <= (den_d_reg == '0);
            side_e_reg.neg_re  <= neg_re_reg;
            side_e_reg.neg_im  <= neg_im_reg;
            side_e_reg.ovf_re  <= ({{(cau_pkg::DEN_W-cau_pkg::HI_W){1'b0}}, hi_re} >= den_d_reg);
            side_e_reg.ovf_im  <= ({{(cau_pkg::DEN_W-cau_pkg::HI_W){1'b0}}, hi_im} >= den_d_reg);
            side_e_reg.alt_re  <= sat_re.val;
            side_e_reg.alt_im  <= sat_im.val;
            side_e_reg.alt_sat <= sat_re.sat | sat_im.sat;
            den_e_reg  <= den_d_reg;
            rem_re_reg <= {{(cau_pkg::DEN_W-cau_pkg::HI_W){1'b0}}, hi_re};
            rem_im_reg <= {{(cau_pkg::DEN_W-cau_pkg::HI_W){1'b0}}, hi_im};
            nb_re_reg  <= sh_re[cau_pkg::QUO_W-1:0];
            nb_im_reg  <= sh_im[cau_pkg::QUO_W-1:0];
        end
    end

    assign out_valid  = valid_reg[4];
    assign out_side   = side_e_reg;
    assign out_den    = den_e_reg;
    assign out_rem_re = rem_re_reg;
    assign out_nb_re  = nb_re_reg;
    assign out_rem_im = rem_im_reg;
    assign out_nb_im  = nb_im_reg;

endmodule

[rtl/core/cau_div_step.sv]
// One restoring-division step for the real and imaginary quotients.
module cau_div_step (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  cau_pkg::side_t             in_side,
    input  logic [cau_pkg::DEN_W-1:0]  in_den,
    input  logic [cau_pkg::DEN_W-1:0]  in_rem_re,
    input  logic [cau_pkg::QUO_W-1:0]  in_nb_re,
    input  logic [cau_pkg::DEN_W-1:0]  in_rem_im,
    input  logic [cau_pkg::QUO_W-1:0]  in_nb_im,
    output logic                       out_valid,
    output cau_pkg::side_t             out_side,
    output logic [cau_pkg::DEN_W-1:0]  out_den,
    output logic [cau_pkg::DEN_W-1:0]  out_rem_re,
    output logic [cau_pkg::QUO_W-1:0]  out_nb_re,
    output logic [cau_pkg::DEN_W-1:0]  out_rem_im,
    output logic [cau_pkg::QUO_W-1:0]  out_nb_im
);

    logic                       valid_reg;
    cau_pkg::side_t             side_reg;
    logic [cau_pkg::DEN_W-1:0]  den_reg, rem_re_reg, rem_im_reg;
    logic [cau_pkg::QUO_W-1:0]  nb_re_reg, nb_im_reg;

    logic [cau_pkg::REM_W-1:0]  t_re, t_im, d_ext, df_re, df_im;
    logic                       ge_re, ge_im;

    // Shift in the next numerator bit and trial-subtract
    always_comb
    begin
        d_ext = {1'b0, in_den};
        t_re  = {in_rem_re, in_nb_re[cau_pkg::QUO_W-1]};
        t_im  = {in_rem_im, in_nb_im[cau_pkg::QUO_W-1]};
        ge_re = (t_re >= d_ext);
        ge_im = (t_im >= d_ext);
        df_re = t_re - d_ext;
        df_im = t_im - d_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Keep the remainder, push the quotient bit in at the bottom
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg   <= in_side;
            den_reg    <= in_den;
            rem_re_reg <= ge_re ? df_re[cau_pkg::DEN_W-1:0] : t_re[cau_pkg::DEN_W-1:0];
            rem_im_reg <= ge_im ? df_im[cau_pkg::DEN_W-1:0] : t_im[cau_pkg::DEN_W-1:0];
            nb_re_reg  <= {in_nb_re[cau_pkg::QUO_W-2:0], ge_re};
            nb_im_reg  <= {in_nb_im[cau_pkg::QUO_W-2:0], ge_im};
        end
    end

    assign out_valid  = valid_reg;
    assign out_side   = side_reg;
    assign out_den    = den_reg;
    assign out_rem_re = rem_re_reg;
    assign out_nb_re  = nb_re_reg;
    assign out_rem_im = rem_im_reg;
    assign out_nb_im  = nb_im_reg;

endmodule

[rtl/core/complex_arithmetic_unit_top.sv]
// Top level of the complex arithmetic unit: front stages, divider chain, output register.
//
// Usage: each transfer on the s_ channel carries two complex Q16.16 operands in
// s_tdata and the operation in s_tuser (add, subtract, multiply, divide). Each
// accepted item yields exactly one transfer on the m_ channel: the result parts
// in m_tdata and a status code in m_tuser (ok, divide by zero, saturated).
// Every operation passes through one operand register, a product
// stage, a sum stage, a magnitude stage, a divider setup stage, 33 restoring
// division steps (one quotient bit each) and the output register. All items go
// through the same chain, so order is kept.
// Throughput: one item per cycle unless stalled; the 33-step divider chain sets depth.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated, and bubbles pass as invalid
// stages. Reset clears the valid bits only; the block is ready right after.
module complex_arithmetic_unit_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [4*cau_pkg::DATA_WIDTH-1:0] s_tdata,   // a_re, a_im, b_re, b_im
    input  logic [1:0]                       s_tuser,   // func
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [2*cau_pkg::DATA_WIDTH-1:0] m_tdata,   // res_re, res_im
    output logic [1:0]                       m_tuser    // status
);

    localparam int STEPS = cau_pkg::QUO_W;
    localparam int W     = cau_pkg::DATA_WIDTH;

    logic                      en;
    logic                      v_c    [0:STEPS];
    cau_pkg::side_t            side_c [0:STEPS];
    logic [cau_pkg::DEN_W-1:0] den_c  [0:STEPS];
    logic [cau_pkg::DEN_W-1:0] rre_c  [0:STEPS];
    logic [cau_pkg::QUO_W-1:0] nre_c  [0:STEPS];
    logic [cau_pkg::DEN_W-1:0] rim_c  [0:STEPS];
    logic [cau_pkg::QUO_W-1:0] nim_c  [0:STEPS];

    logic                      m_valid_reg;
    logic [2*W-1:0]            m_data_reg;
    logic [1:0]                m_user_reg;
    logic [2*W-1:0]            data_next;
    logic [1:0]                user_next;
    cau_pkg::sat_t             q_re, q_im;
    cau_pkg::side_t            fs;

    // Advance everything when the output slot is free or being taken
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    cau_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_tvalid),
        .in_func    (s_tuser),
        .in_data    (s_tdata),
        .out_valid  (v_c[0]),
        .out_side   (side_c[0]),
        .out_den    (den_c[0]),
        .out_rem_re (rre_c[0]),
        .out_nb_re  (nre_c[0]),
        .out_rem_im (rim_c[0]),
        .out_nb_im  (nim_c[0])
    );

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        cau_div_step u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .in_valid   (v_c[i]),
            .in_side    (side_c[i]),
            .in_den     (den_c[i]),
            .in_rem_re  (rre_c[i]),
            .in_nb_re   (nre_c[i]),
            .in_rem_im  (rim_c[i]),
            .in_nb_im   (nim_c[i]),
            .out_valid  (v_c[i+1]),
            .out_side   (side_c[i+1]),
            .out_den    (den_c[i+1]),
            .out_rem_re (rre_c[i+1]),
            .out_nb_re  (nre_c[i+1]),
            .out_rem_im (rim_c[i+1]),
            .out_nb_im  (nim_c[i+1])
        );
    end

    // Select the final result and status
    always_comb
    begin
        fs   = side_c[STEPS];
        q_re = cau_pkg::sat_quot(fs.neg_re, fs.ovf_re, nre_c[STEPS]);
        q_im = cau_pkg::sat_quot(fs.neg_im, fs.ovf_im, nim_c[STEPS]);
        if (!fs.is_div)
        begin
            data_next = {fs.alt_im, fs.alt_re};
            user_next = fs.alt_sat ? cau_pkg::STAT_SAT : cau_pkg::STAT_OK;
        end
        else if (fs.dz)
        begin
            data_next = '0;
            user_next = cau_pkg::STAT_DZ;
        end
        else
        begin
            data_next = {q_im.val, q_re.val};
            user_next = (q_re.sat || q_im.sat) ? cau_pkg::STAT_SAT : cau_pkg::STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= v_c[STEPS];
        end
    end

    // Hold the result until the transfer completes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_data_reg <= data_next;
            m_user_reg <= user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

[rtl/core/cau_checker.sv]
// Port-level checks of the complex arithmetic unit, bound to the top level.
module cau_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [2*cau_pkg::DATA_WIDTH-1:0] m_tdata,
    input logic [1:0]                       m_tuser
);

    localparam int W = cau_pkg::DATA_WIDTH;

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Status code 3 is never produced
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("unused status code");

    // Divide by zero returns zero parts
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == cau_pkg::STAT_DZ |-> m_tdata == '0)
        else $error("divide by zero result not zero");

    // A saturated status shows a clamped part
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == cau_pkg::STAT_SAT |->
            m_tdata[W-1:0] == cau_pkg::WORD_MAX || m_tdata[W-1:0] == cau_pkg::WORD_MIN ||
            m_tdata[2*W-1:W] == cau_pkg::WORD_MAX || m_tdata[2*W-1:W] == cau_pkg::WORD_MIN)
        else $error("saturated status without clamped part");

    // Ready follows the output slot
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[bench/complex_arithmetic_unit_top_tb.sv]
// Self-checking testbench for the complex arithmetic unit: directed table, random items, predictor.
`timescale 1ns / 100ps

module complex_arithmetic_unit_top_tb;

    localparam int RANDOM_ITEMS = 1730;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] a_re;
        logic [31:0] a_im;
        logic [31:0] b_re;
        logic [31:0] b_im;
        bit          typed;
        logic [31:0] t_re;
        logic [31:0] t_im;
        logic [1:0]  t_status;
    } op_item_t;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic [1:0]  status;
    } cplx_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;

    op_item_t     ops[$];
    cplx_result_t pending_results[$];
    int           op_idx;
    int           cycles;
    int           mismatches;
    int           results_seen;
    int           func_count[4];
    int           status_count[4];

    complex_arithmetic_unit_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Clamp a wide value to the word range, flag clamping
    function automatic logic [31:0] clamp_word(input logic signed [127:0] x, inout bit sat);
        if (x > 128'sd2147483647)
        begin
            sat = 1'b1;
            return cau_pkg::WORD_MAX;
        end
        if (x < -128'sd2147483648)
        begin
            sat = 1'b1;
            return cau_pkg::WORD_MIN;
        end
        return x[31:0];
    endfunction

    // Exact complex result of one operation, rescaled and saturated
    function automatic cplx_result_t complex_result(input op_item_t op);
        logic signed [127:0] ar;
        logic signed [127:0] ai;
        logic signed [127:0] br;
        logic signed [127:0] bi;
        logic signed [127:0] xr;
        logic signed [127:0] xi;
        logic signed [127:0] den;
        cplx_result_t r;
        bit sat;
        ar  = $signed(op.a_re);
        ai  = $signed(op.a_im);
        br  = $signed(op.b_re);
        bi  = $signed(op.b_im);
        sat = 1'b0;
        case (op.func)
            cau_pkg::FUNC_ADD:
            begin
                xr = ar + br;
                xi = ai + bi;
            end
            cau_pkg::FUNC_SUB:
            begin
                xr = ar - br;
                xi = ai - bi;
            end
            cau_pkg::FUNC_MUL:
            begin
                xr = (ar * br - ai * bi) >>> cau_pkg::FRAC_BITS;
                xi = (ar * bi + ai * br) >>> cau_pkg::FRAC_BITS;
            end
            default:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                begin
                    r.re     = '0;
                    r.im     = '0;
                    r.status = cau_pkg::STAT_DZ;
                    return r;
                end
                xr = ((ar * br + ai * bi) <<< cau_pkg::FRAC_BITS) / den;
                xi = ((ai * br - ar * bi) <<< cau_pkg::FRAC_BITS) / den;
            end
        endcase
        r.re     = clamp_word(xr, sat);
        r.im     = clamp_word(xi, sat);
        r.status = sat ? cau_pkg::STAT_SAT : cau_pkg::STAT_OK;
        return r;
    endfunction

    function automatic op_item_t make_op(input logic [1:0] f, input logic [31:0] ar,
                                         input logic [31:0] ai, input logic [31:0] br,
                                         input logic [31:0] bi);
        op_item_t op;
        op.func = f;
        op.a_re = ar;
        op.a_im = ai;
        op.b_re = br;
        op.b_im = bi;
        op.typed = 1'b0;
        op.t_re = '0;
        op.t_im = '0;
        op.t_status = cau_pkg::STAT_OK;
        return op;
    endfunction

    function automatic op_item_t typed_op(input op_item_t op, input logic [31:0] re,
                                          input logic [31:0] im, input logic [1:0] st);
        op.typed    = 1'b1;
        op.t_re     = re;
        op.t_im     = im;
        op.t_status = st;
        return op;
    endfunction

    // Operand value: full random, small or medium Q16.16, extreme or within two LSBs of zero
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            7:          return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
            8:          return $urandom_range(0, 1) ? cau_pkg::WORD_MAX : cau_pkg::WORD_MIN;
            default:    return $signed($urandom_range(0, 4)) - 2;
        endcase
    endfunction

    // Build the stimulus list: directed table first, then random items
    initial
    begin
        op_item_t op;
        ops.push_back(typed_op(make_op(cau_pkg::FUNC_ADD, 0, 0, 0, 0), 0, 0,
                               cau_pkg::STAT_OK));
        ops.push_back(typed_op(make_op(cau_pkg::FUNC_ADD, cau_pkg::WORD_MAX,
                                       cau_pkg::WORD_MIN, 1, 32'hFFFF_FFFF),
                               cau_pkg::WORD_MAX, cau_pkg::WORD_MIN, cau_pkg::STAT_SAT));
        ops.push_back(typed_op(make_op(cau_pkg::FUNC_ADD, cau_pkg::WORD_MAX, 0,
                                       cau_pkg::WORD_MIN, 0),
                               32'hFFFF_FFFF, 0, cau_pkg::STAT_OK));
        ops.push_back(typed_op(make_op(cau_pkg::FUNC_SUB, cau_pkg::WORD_MIN,
                                       cau_pkg::WORD_MAX, 1, 32'hFFFF_FFFF),
                               cau_pkg::WORD_MIN, cau_pkg::WORD_MAX, cau_pkg::STAT_SAT));
        ops.push_back(typed_op(make_op(cau_pkg::FUNC_SUB, 32'h0003_0000, 0,
                                       32'h0001_0000, 0),
                               32'h0002_0000, 0, cau_pkg::STAT_OK));
        ops.push_back(typed_op(make_op(cau_pkg::FUNC_MUL, 32'h0001_0000, 32'h0002_0000,
                                       32'h0001_0000, 0),
                               32'h0001_0000, 32'h0002_0000, cau_pkg::STAT_OK));
        ops.push_back(typed_op(make_op(cau_pkg::FUNC_MUL, 0, 32'h0001_0000, 0,
                                       32'h0001_0000),
                               32'hFFFF_0000, 0, cau_pkg::STAT_OK));
        ops.push_back(typed_op(make_op(cau_pkg::FUNC_MUL, cau_pkg::WORD_MIN,
                                       cau_pkg::WORD_MIN, cau_pkg::WORD_MIN,
                                       cau_pkg::WORD_MIN),
                               0, cau_pkg::WORD_MAX, cau_pkg::STAT_SAT));
        ops.push_back(make_op(cau_pkg::FUNC_MUL, cau_pkg::WORD_MAX, cau_pkg::WORD_MIN,
                              cau_pkg::WORD_MAX, cau_pkg::WORD_MAX));
        ops.push_back(make_op(cau_pkg::FUNC_MUL, 32'hFFFF_FFFF, 0, 1, 0));
        ops.push_back(typed_op(make_op(cau_pkg::FUNC_DIV, 32'h0001_0000, 32'h0001_0000,
                                       0, 0),
                               0, 0, cau_pkg::STAT_DZ));
        ops.push_back(typed_op(make_op(cau_pkg::FUNC_DIV, cau_pkg::WORD_MAX,
                                       cau_pkg::WORD_MIN, 0, 0),
                               0, 0, cau_pkg::STAT_DZ));
        ops.push_back(typed_op(make_op(cau_pkg::FUNC_DIV, 32'h0004_0000, 32'h0002_0000,
                                       32'h0002_0000, 0),
                               32'h0002_0000, 32'h0001_0000, cau_pkg::STAT_OK));
        ops.push_back(make_op(cau_pkg::FUNC_DIV, 32'hFFFF_FFFF, 0, 32'h0003_0000, 0));
        ops.push_back(make_op(cau_pkg::FUNC_DIV, cau_pkg::WORD_MAX, cau_pkg::WORD_MAX, 1, 0));
        ops.push_back(make_op(cau_pkg::FUNC_DIV, cau_pkg::WORD_MIN, cau_pkg::WORD_MIN,
                              cau_pkg::WORD_MIN, cau_pkg::WORD_MIN));
        ops.push_back(make_op(cau_pkg::FUNC_DIV, 1, 0, cau_pkg::WORD_MAX, cau_pkg::WORD_MIN));
        ops.push_back(make_op(cau_pkg::FUNC_DIV, 32'h0001_0000, 0, 0, 32'hFFFF_FFFF));
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            op = make_op(2'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                         rand_operand(), rand_operand());
            // drop the divisor to zero now and then
            if (op.func == cau_pkg::FUNC_DIV && $urandom_range(0, 19) == 0)
            begin
                op.b_re = '0;
                op.b_im = '0;
            end
            ops.push_back(op);
        end
    end

    // Random idling, except a quiet stretch with no idling on either side
    function automatic bit idle_now();
        if (cycles > 600 && cycles < 1100)
            return 1'b0;
        return $urandom_range(0, 99) < 9;
    endfunction

    // Source side: advance on each transfer, idle at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= cau_pkg::FUNC_ADD;
            op_idx   <= 0;
        end
        else
        begin
            int nxt;
            nxt = op_idx;
            if (s_tvalid && s_tready)
            begin
                if (ops[op_idx].typed)
                    pending_results.push_back('{ops[op_idx].t_re, ops[op_idx].t_im,
                                                ops[op_idx].t_status});
                else
                    pending_results.push_back(complex_result(ops[op_idx]));
                func_count[ops[op_idx].func]++;
                nxt = op_idx + 1;
            end
            op_idx <= nxt;
            if (!s_tvalid || s_tready)
            begin
                if (nxt < ops.size() && !idle_now())
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {ops[nxt].b_im, ops[nxt].b_re, ops[nxt].a_im, ops[nxt].a_re};
                    s_tuser  <= ops[nxt].func;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: stall at random, check each transfer against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= !idle_now();
            if (m_tvalid && m_tready)
            begin
                cplx_result_t want;
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0d] unexpected result re=%h im=%h status=%0d",
                                 cycles, m_tdata[31:0], m_tdata[63:32], m_tuser);
                end
                else
                begin
                    want = pending_results.pop_front();
                    status_count[m_tuser]++;
                    if (m_tdata[31:0] !== want.re || m_tdata[63:32] !== want.im
                        || m_tuser !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0d] result %0d: want %h %h %0d, got %h %h %0d",
                                     cycles, results_seen, want.re, want.im, want.status,
                                     m_tdata[31:0], m_tdata[63:32], m_tuser);
                    end
                end
            end
        end
    end

    // Cycle counter and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("FAIL complex_arithmetic_unit_top");
            $finish;
        end
    end

    // Wait for all transfers and results, then drain and report
    initial
    begin
        cycles = 0;
        mismatches = 0;
        results_seen = 0;
        wait (rst_n === 1'b1);
        wait (ops.size() > 0 && op_idx == ops.size() && pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            mismatches++;
        $display("covered %0d operations: add %0d, sub %0d, mul %0d, div %0d",
                 op_idx, func_count[0], func_count[1], func_count[2], func_count[3]);
        $display("results %0d: ok %0d, divide by zero %0d, saturated %0d, mismatches %0d",
                 results_seen, status_count[0], status_count[1], status_count[2], mismatches);
        if (mismatches == 0)
            $display("PASS complex_arithmetic_unit_top");
        else
            $display("FAIL complex_arithmetic_unit_top");
        $finish;
    end

endmodule
